/* rtl/core/tmdq_pkg.sv */
// Package: constants, types and helpers shared by the timestamp-matching delay queue.
`default_nettype none
package tmdq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned QL_W        = 5;
  localparam int unsigned POS_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W     = HANDLE_BITS + TIME_W;
  localparam int unsigned DIFF_W      = 31;
  localparam logic [DIFF_W-1:0] INT_MAX = {DIFF_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INDEX  = 3'd1,
    CMD_NEAR   = 3'd2,
    CMD_RUN    = 3'd3,
    CMD_NEWEST = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RD,
    ST_WR,
    ST_NF
  } state_e;

  // Control from the sequencer to the nearest-timestamp search unit.
  typedef struct packed {
    logic             start;
    logic             rd_vld;
    logic [POS_W-1:0] rd_pos;
  } search_ctl_t;

  // Status from the search unit back to the sequencer.
  typedef struct packed {
    logic             busy;
    logic             hit;
    logic [POS_W-1:0] pos;
  } search_res_t;

  // Physical slot of a position counted from the oldest entry.
  function automatic logic [POS_W-1:0] slot_of(logic [POS_W-1:0] ptr,
                                                logic [POS_W-1:0] pos);
    logic [POS_W:0] sum;
    sum = {1'b0, ptr} + {1'b0, pos};
    if (sum >= (POS_W + 1)'(DEPTH)) begin
      sum = sum - (POS_W + 1)'(DEPTH);
    end
    return sum[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tmdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/tmdq_search.sv */
// Nearest-timestamp search: saturated distance stage followed by a best-so-far compare.
`default_nettype none
module tmdq_search (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tmdq_pkg::search_ctl_t                ctl_i,
  input  wire logic signed [tmdq_pkg::TIME_W-1:0]   target_i,
  input  wire logic signed [tmdq_pkg::TIME_W-1:0]   rd_time_i,
  output tmdq_pkg::search_res_t                     res_o
);
  import tmdq_pkg::*;

  logic [TIME_W:0]   diff;
  logic [31:0]       mag;
  logic              in_range;
  logic [DIFF_W-1:0] sat;

  logic              diff_vld_q;
  logic [DIFF_W-1:0] diff_q;
  logic [POS_W-1:0]  diff_pos_q;
  logic [DIFF_W-1:0] best_q, best_d;
  logic              hit_q, hit_d;
  logic [POS_W-1:0]  best_pos_q, best_pos_d;

  always_comb begin
    diff = {target_i[TIME_W-1], target_i} - {rd_time_i[TIME_W-1], rd_time_i};
    // Fits when bits 31 and up are a pure sign run; exclude -2^31 too.
    in_range = (diff[TIME_W:DIFF_W] == '0) ||
               ((diff[TIME_W:DIFF_W] == '1) && (diff[DIFF_W-1:0] != '0));
    mag = diff[TIME_W] ? (32'd0 - diff[31:0]) : diff[31:0];
    sat = in_range ? mag[DIFF_W-1:0] : INT_MAX;
  end

  always_comb begin
    best_d     = best_q;
    hit_d      = hit_q;
    best_pos_d = best_pos_q;
    if (ctl_i.start) begin
      best_d = INT_MAX;
      hit_d  = 1'b0;
    end else if (diff_vld_q && (diff_q < best_q)) begin
      best_d     = diff_q;
      hit_d      = 1'b1;
      best_pos_d = diff_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      diff_vld_q <= ctl_i.rd_vld;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q     <= sat;
    diff_pos_q <= ctl_i.rd_pos;
    best_q     <= best_d;
    best_pos_q <= best_pos_d;
  end

  assign res_o.busy = diff_vld_q;
  assign res_o.hit  = hit_q;
  assign res_o.pos  = best_pos_q;

endmodule
`default_nettype wire

/* rtl/core/tmdq_ctrl.sv */
// Sequencer: queue pointers, command decode, memory access and the result register.
`default_nettype none
module tmdq_ctrl (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_valid_i,
  input  wire logic [tmdq_pkg::QL_W-1:0]            cfg_data_i,
  // request
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [2:0]                           in_cmd_i,
  input  wire logic [15:0]                          in_handle_i,
  input  wire logic signed [tmdq_pkg::TIME_W-1:0]   in_time_i,
  input  wire logic [3:0]                           in_index_i,
  input  wire logic [4:0]                           in_run_i,
  // memory
  output logic                                      ram_we_o,
  output logic [tmdq_pkg::POS_W-1:0]                ram_waddr_o,
  output logic [tmdq_pkg::ENTRY_W-1:0]              ram_wdata_o,
  output logic                                      ram_re_o,
  output logic [tmdq_pkg::POS_W-1:0]                ram_raddr_o,
  input  wire logic [tmdq_pkg::ENTRY_W-1:0]         ram_rdata_i,
  // search unit
  output tmdq_pkg::search_ctl_t                     search_ctl_o,
  output logic signed [tmdq_pkg::TIME_W-1:0]        target_o,
  input  wire tmdq_pkg::search_res_t                search_res_i,
  // result
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_found_o,
  output logic                                      out_evicted_o,
  output logic [15:0]                               out_handle_o,
  output logic signed [tmdq_pkg::TIME_W-1:0]        out_time_o,
  output logic [4:0]                                out_count_o,
  output logic                                      out_last_o
);
  import tmdq_pkg::*;

  state_e                   state_q, state_d;
  logic [POS_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [QL_W-1:0]          ql_q;
  cmd_e                     cmd_q, cmd_d;
  logic [HANDLE_BITS-1:0]   hold_handle_q, hold_handle_d;
  logic signed [TIME_W-1:0] hold_time_q, hold_time_d;
  logic [4:0]               run_q, run_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         left_q, left_d;
  logic                     dir_q, dir_d;
  logic                     evict_q, evict_d;
  logic                     fwd_q, fwd_d;
  logic                     rd_pend_q, rd_pend_d;
  logic [POS_W-1:0]         rd_pos_q, rd_pos_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q, out_evicted_q, out_last_q;
  logic [15:0]              out_handle_q;
  logic signed [TIME_W-1:0] out_time_q;
  logic [4:0]               out_count_q;

  logic                     load;
  logic                     load_found;
  logic                     load_last;
  logic [HANDLE_BITS-1:0]   load_handle;
  logic signed [TIME_W-1:0] load_time;
  logic                     out_free;
  logic [CNT_W-1:0]         eff;
  logic                     start;

  assign out_free = !out_valid_q || out_ready_i;

  // Clamp the queue length to 1..DEPTH.
  always_comb begin
    if (ql_q == '0) begin
      eff = CNT_W'(1);
    end else if (int'(ql_q) > int'(DEPTH)) begin
      eff = CNT_W'(DEPTH);
    end else begin
      eff = CNT_W'(ql_q);
    end
  end

  always_comb begin
    int avail;
    int n;
    avail = 0;
    n     = 0;

    state_d       = state_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    cmd_d         = cmd_q;
    hold_handle_d = hold_handle_q;
    hold_time_d   = hold_time_q;
    run_d         = run_q;
    pos_d         = pos_q;
    left_d        = left_q;
    dir_d         = dir_q;
    evict_d       = evict_q;
    fwd_d         = fwd_q;
    rd_pend_d     = 1'b0;
    rd_pos_d      = rd_pos_q;
    start         = 1'b0;

    ram_we_o      = 1'b0;
    ram_waddr_o   = slot_of(ptr_q, POS_W'(cnt_q));
    ram_wdata_o   = {HANDLE_BITS'(in_handle_i), in_time_i};
    ram_re_o      = 1'b0;
    ram_raddr_o   = slot_of(ptr_q, pos_q);

    load          = 1'b0;
    load_found    = 1'b1;
    load_last     = 1'b0;
    load_handle   = fwd_q ? hold_handle_q : ram_rdata_i[ENTRY_W-1:TIME_W];
    load_time     = fwd_q ? hold_time_q : ram_rdata_i[TIME_W-1:0];

    in_ready_o    = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d         = cmd_e'(in_cmd_i);
          hold_handle_d = HANDLE_BITS'(in_handle_i);
          hold_time_d   = in_time_i;
          run_d         = in_run_i;
          evict_d       = 1'b0;
          fwd_d         = 1'b0;
          dir_d         = 1'b0;
          priority case (cmd_e'(in_cmd_i))
            CMD_PUSH: begin
              ram_we_o = 1'b1;
              if ((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(eff)) begin
                // Read the oldest slot; when the queue was empty it is the new entry.
                ram_re_o    = 1'b1;
                ram_raddr_o = ptr_q;
                fwd_d       = (cnt_q == '0);
                evict_d     = 1'b1;
                left_d      = CNT_W'(1);
                ptr_d       = slot_of(ptr_q, POS_W'(1));
                state_d     = ST_WR;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            CMD_INDEX: begin
              if (int'(in_index_i) < int'(cnt_q)) begin
                pos_d   = POS_W'(in_index_i);
                left_d  = CNT_W'(1);
                state_d = ST_RD;
              end else begin
                state_d = ST_NF;
              end
            end
            CMD_NEAR, CMD_RUN: begin
              if (cnt_q == '0) begin
                state_d = ST_NF;
              end else begin
                start   = 1'b1;
                pos_d   = POS_W'(cnt_q - CNT_W'(1));
                state_d = ST_SCAN;
              end
            end
            CMD_NEWEST: begin
              n = (int'(in_run_i) < int'(cnt_q)) ? int'(in_run_i) : int'(cnt_q);
              if (n > int'(MAX_RESULTS)) begin
                n = int'(MAX_RESULTS);
              end
              if (n == 0) begin
                state_d = ST_NF;
              end else begin
                pos_d   = POS_W'(cnt_q - CNT_W'(1));
                dir_d   = 1'b1;
                left_d  = CNT_W'(n);
                state_d = ST_RD;
              end
            end
            default: begin
              state_d = ST_NF;
            end
          endcase
        end
      end

      // Walk newest to oldest, one read per cycle.
      ST_SCAN: begin
        ram_re_o  = 1'b1;
        rd_pend_d = 1'b1;
        rd_pos_d  = pos_q;
        if (pos_q == '0) begin
          state_d = ST_DRAIN;
        end else begin
          pos_d = pos_q - POS_W'(1);
        end
      end

      ST_DRAIN: begin
        if (!rd_pend_q && !search_res_i.busy) begin
          if (!search_res_i.hit) begin
            state_d = ST_NF;
          end else begin
            avail = int'(cnt_q) - int'(search_res_i.pos);
            if (cmd_q == CMD_NEAR) begin
              n = 1;
            end else begin
              n = (int'(run_q) < avail) ? int'(run_q) : avail;
            end
            if (n > int'(MAX_RESULTS)) begin
              n = int'(MAX_RESULTS);
            end
            if (n == 0) begin
              state_d = ST_NF;
            end else begin
              pos_d   = search_res_i.pos;
              left_d  = CNT_W'(n);
              state_d = ST_RD;
            end
          end
        end
      end

      ST_RD: begin
        ram_re_o = 1'b1;
        state_d  = ST_WR;
      end

      ST_WR: begin
        if (out_free) begin
          load      = 1'b1;
          load_last = (left_q == CNT_W'(1));
          left_d    = left_q - CNT_W'(1);
          pos_d     = dir_q ? (pos_q - POS_W'(1)) : (pos_q + POS_W'(1));
          state_d   = (left_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end

      ST_NF: begin
        if (out_free) begin
          load        = 1'b1;
          load_found  = 1'b0;
          load_last   = 1'b1;
          load_handle = '0;
          load_time   = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      ql_q        <= QL_W'(1);
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        ql_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    hold_handle_q <= hold_handle_d;
    hold_time_q   <= hold_time_d;
    run_q         <= run_d;
    pos_q         <= pos_d;
    left_q        <= left_d;
    dir_q         <= dir_d;
    evict_q       <= evict_d;
    fwd_q         <= fwd_d;
    rd_pos_q      <= rd_pos_d;
    if (load) begin
      out_found_q   <= load_found;
      out_evicted_q <= load_found && evict_q;
      out_handle_q  <= 16'(load_handle);
      out_time_q    <= load_time;
      out_count_q   <= 5'(cnt_q);
      out_last_q    <= load_last;
    end
  end

  assign search_ctl_o.start  = start;
  assign search_ctl_o.rd_vld = rd_pend_q;
  assign search_ctl_o.rd_pos = rd_pos_q;
  assign target_o            = hold_time_q;

  assign out_valid_o   = out_valid_q;
  assign out_found_o   = out_found_q;
  assign out_evicted_o = out_evicted_q;
  assign out_handle_o  = out_handle_q;
  assign out_time_o    = out_time_q;
  assign out_count_o   = out_count_q;
  assign out_last_o    = out_last_q;

endmodule
`default_nettype wire

/* rtl/core/timestamp_matching_delay_queue_top.sv */
// Top level of the timestamp-matching delay queue: stream ports, entry memory and search unit.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------------
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_data_i = queue_length
//  s_axis   | in        | s_axis_tvalid/tready    | request: push or one of four queries
//  m_axis   | out       | m_axis_tvalid/tready    | result entries, tlast on the final one
//
// One request is worked at a time; a new one is taken while the last result still waits.
// A push without eviction gives no result; a push with eviction returns the evicted entry.
// Nearest and run-from-nearest: one memory read per stored entry, then a read state and a
// write state per result. Index and newest run: read and write per result; a miss answers not-found.
// Reset clears pointers, count and control; data read from an unwritten entry is never used.
// A stalled result port holds the sequencer in place; no request is lost.
`default_nettype none
module timestamp_matching_delay_queue_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // buffer_handle, capture_time, entry_index, run_length
  input  wire logic [2:0]  s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // out_handle, out_time, stored_count
  output logic [1:0]       m_axis_tuser,   // found, evicted
  output logic             m_axis_tlast
);
  import tmdq_pkg::*;

  logic                     ram_we;
  logic [POS_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [POS_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  search_ctl_t              search_ctl;
  search_res_t              search_res;
  logic signed [TIME_W-1:0] target;
  logic                     out_found;
  logic                     out_evicted;
  logic [15:0]              out_handle;
  logic signed [TIME_W-1:0] out_time;
  logic [4:0]               out_count;

  assign cfg_ready_o = 1'b1;

  tmdq_ram #(
    .Width (ENTRY_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmdq_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (search_ctl),
    .target_i  (target),
    .rd_time_i (ram_rdata[TIME_W-1:0]),
    .res_o     (search_res)
  );

  tmdq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_handle_i   (s_axis_tdata[15:0]),
    .in_time_i     (s_axis_tdata[79:16]),
    .in_index_i    (s_axis_tdata[83:80]),
    .in_run_i      (s_axis_tdata[88:84]),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .search_ctl_o  (search_ctl),
    .target_o      (target),
    .search_res_i  (search_res),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_found_o   (out_found),
    .out_evicted_o (out_evicted),
    .out_handle_o  (out_handle),
    .out_time_o    (out_time),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_count, out_time, out_handle};
  assign m_axis_tuser = {out_evicted, out_found};

endmodule
`default_nettype wire
